>>> rtl/mrfc_pkg.sv
// ----------------------------------------------------------------------------
// mrfc_pkg
// Shared types and constants for the Modbus RTU frame checker.
// ----------------------------------------------------------------------------
package mrfc_pkg;

    localparam int MAX_FRAME   = 256;

    localparam int BYTE_W      = 8;
    localparam int CRC_W       = 16;
    localparam int LEN_W       = 9;
    localparam int CFG_INDEX_W = 8;

    localparam logic [CRC_W-1:0]  CRC_INIT      = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY      = 16'hA001;
    localparam logic [LEN_W-1:0]  MIN_VALID_LEN = 9'd4;
    localparam logic [LEN_W-1:0]  HEARTBEAT_LEN = 9'd7;
    localparam logic [BYTE_W-1:0] MAX_FUNCTION  = 8'd127;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ADDRESS        = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEARTBEAT_ADDRESS  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEARTBEAT_FUNCTION = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEARTBEAT_COUNT    = 8'd3;

    localparam logic [BYTE_W-1:0] RST_MAX_ADDRESS        = 8'd247;
    localparam logic [BYTE_W-1:0] RST_HEARTBEAT_ADDRESS  = 8'd1;
    localparam logic [BYTE_W-1:0] RST_HEARTBEAT_FUNCTION = 8'd3;
    localparam logic [BYTE_W-1:0] RST_HEARTBEAT_COUNT    = 8'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] max_address;
        logic [BYTE_W-1:0] heartbeat_address;
        logic [BYTE_W-1:0] heartbeat_function;
        logic [BYTE_W-1:0] heartbeat_count;
    } t_cfg;

endpackage

>>> rtl/mrfc_crc_byte.sv
// ----------------------------------------------------------------------------
// mrfc_crc_byte
// One-byte CRC-16/MODBUS update, reflected, eight bit steps unrolled.
// ----------------------------------------------------------------------------
module mrfc_crc_byte (
    input  logic [mrfc_pkg::CRC_W-1:0]  i_crc,
    input  logic [mrfc_pkg::BYTE_W-1:0] i_byte,
    output logic [mrfc_pkg::CRC_W-1:0]  o_crc
);

    always_comb begin
        logic [mrfc_pkg::CRC_W-1:0] v_crc;
        v_crc = i_crc ^ {{(mrfc_pkg::CRC_W-mrfc_pkg::BYTE_W){1'b0}}, i_byte};
        for (int k = 0; k < mrfc_pkg::BYTE_W; k++) begin
            if (v_crc[0]) begin
                v_crc = (v_crc >> 1) ^ mrfc_pkg::CRC_POLY;
            end else begin
                v_crc = v_crc >> 1;
            end
        end
        o_crc = v_crc;
    end

endmodule

>>> rtl/mrfc_cfg_regs.sv
// ----------------------------------------------------------------------------
// mrfc_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module mrfc_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mrfc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [mrfc_pkg::BYTE_W-1:0]      i_cfg_data,
    output mrfc_pkg::t_cfg                   o_cfg
);

    mrfc_pkg::t_cfg r_cfg;
    mrfc_pkg::t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                mrfc_pkg::CFG_MAX_ADDRESS:        n_cfg.max_address        = i_cfg_data;
                mrfc_pkg::CFG_HEARTBEAT_ADDRESS:  n_cfg.heartbeat_address  = i_cfg_data;
                mrfc_pkg::CFG_HEARTBEAT_FUNCTION: n_cfg.heartbeat_function = i_cfg_data;
                mrfc_pkg::CFG_HEARTBEAT_COUNT:    n_cfg.heartbeat_count    = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_address        <= mrfc_pkg::RST_MAX_ADDRESS;
            r_cfg.heartbeat_address  <= mrfc_pkg::RST_HEARTBEAT_ADDRESS;
            r_cfg.heartbeat_function <= mrfc_pkg::RST_HEARTBEAT_FUNCTION;
            r_cfg.heartbeat_count    <= mrfc_pkg::RST_HEARTBEAT_COUNT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

>>> rtl/modbus_rtu_frame_checker.sv
// ----------------------------------------------------------------------------
// modbus_rtu_frame_checker
// Running CRC-16/MODBUS, length and header check over received RTU frames.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+-------------------------
//   in       | input     | i_in_valid / o_in_stall | i_byte_value, i_frame_end
//   out      | output    | o_out_valid / i_out_stall | o_frame_valid,
//            |           |                        | o_heartbeat_match, o_frame_length
//   cfg      | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One byte per cycle while o_in_stall is low; a frame result passes through
// the input register, then the result register. Reset is synchronous, active low,
// and restores the registers and an empty frame. The input stalls only when
// a final byte waits in the input register while the result register is
// full and stalled; non-final bytes are absorbed regardless.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_checker #(
    parameter int MAX_FRAME = mrfc_pkg::MAX_FRAME
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [mrfc_pkg::BYTE_W-1:0]      i_byte_value,
    input  logic                             i_frame_end,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_frame_valid,
    output logic                             o_heartbeat_match,
    output logic [mrfc_pkg::LEN_W-1:0]       o_frame_length,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mrfc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [mrfc_pkg::BYTE_W-1:0]      i_cfg_data
);

    localparam logic [mrfc_pkg::LEN_W-1:0] MaxLen = mrfc_pkg::LEN_W'(MAX_FRAME);

    mrfc_pkg::t_cfg cfg;

    logic                          r_in_valid;
    logic [mrfc_pkg::BYTE_W-1:0]   r_in_byte;
    logic                          r_in_end;

    logic [mrfc_pkg::CRC_W-1:0]    r_crc;
    logic [mrfc_pkg::LEN_W-1:0]    r_count;
    logic [mrfc_pkg::BYTE_W-1:0]   r_addr;
    logic [mrfc_pkg::BYTE_W-1:0]   r_func;
    logic [mrfc_pkg::BYTE_W-1:0]   r_bcnt;

    logic                          r_out_valid;
    logic                          r_frame_valid;
    logic                          r_heartbeat;
    logic [mrfc_pkg::LEN_W-1:0]    r_length;

    logic [mrfc_pkg::CRC_W-1:0]    n_crc;
    logic [mrfc_pkg::LEN_W-1:0]    n_count;
    logic [mrfc_pkg::BYTE_W-1:0]   n_addr;
    logic [mrfc_pkg::BYTE_W-1:0]   n_func;
    logic [mrfc_pkg::BYTE_W-1:0]   n_bcnt;
    logic                          n_frame_valid;
    logic                          n_heartbeat;

    logic                          out_free;
    logic                          proc;
    logic                          in_take;
    logic                          crc_ok;

    mrfc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    mrfc_crc_byte u_crc (
        .i_crc  (r_crc),
        .i_byte (r_in_byte),
        .o_crc  (n_crc)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && (!r_in_end || out_free);
    assign in_take    = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_valid && !proc;

    always_comb begin
        n_count = (r_count < MaxLen) ? r_count + 1'b1 : r_count;
        n_addr  = (r_count == 9'd0) ? r_in_byte : r_addr;
        n_func  = (r_count == 9'd1) ? r_in_byte : r_func;
        n_bcnt  = (r_count == 9'd2) ? r_in_byte : r_bcnt;
        crc_ok  = (n_crc == '0);
        n_frame_valid = (n_count >= mrfc_pkg::MIN_VALID_LEN) && crc_ok
                        && (n_addr <= cfg.max_address)
                        && (n_func != '0) && (n_func <= mrfc_pkg::MAX_FUNCTION);
        n_heartbeat   = (n_count == mrfc_pkg::HEARTBEAT_LEN) && crc_ok
                        && (n_addr == cfg.heartbeat_address)
                        && (n_func == cfg.heartbeat_function)
                        && (n_bcnt == cfg.heartbeat_count);
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_byte_value;
            r_in_end  <= i_frame_end;
        end
    end

    // frame state; clear after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= mrfc_pkg::CRC_INIT;
            r_count <= '0;
            r_addr  <= '0;
            r_func  <= '0;
            r_bcnt  <= '0;
        end else if (proc) begin
            if (r_in_end) begin
                r_crc   <= mrfc_pkg::CRC_INIT;
                r_count <= '0;
                r_addr  <= '0;
                r_func  <= '0;
                r_bcnt  <= '0;
            end else begin
                r_crc   <= n_crc;
                r_count <= n_count;
                r_addr  <= n_addr;
                r_func  <= n_func;
                r_bcnt  <= n_bcnt;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && r_in_end) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && r_in_end) begin
            r_frame_valid <= n_frame_valid;
            r_heartbeat   <= n_heartbeat;
            r_length      <= n_count;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_frame_valid     = r_frame_valid;
    assign o_heartbeat_match = r_heartbeat;
    assign o_frame_length    = r_length;

endmodule

>>> tb/sv/modbus_rtu_frame_checker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modbus_rtu_frame_checker_tb
// Drives Modbus RTU frames byte by byte into the frame checker. Frames are
// heartbeat replies, requests with chosen header bytes, short and noise
// frames, and frames below, at and past the saturation length. Each byte's effect
// on the CRC, the length and the header is predicted in the bench. Every
// frame result is compared with the oldest predicted result. Register
// settings change between phases while the checker is idle. Random gaps
// and stalls are applied on the input and output handshakes.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_checker_tb;

    import mrfc_pkg::*;

    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef logic [BYTE_W-1:0] byte_q_t[$];

    typedef struct packed {
        logic             frame_valid;
        logic             heartbeat_match;
        logic [LEN_W-1:0] frame_length;
    } frame_result_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [BYTE_W-1:0]      i_byte_value;
    logic                   i_frame_end;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic                   o_frame_valid;
    logic                   o_heartbeat_match;
    logic [LEN_W-1:0]       o_frame_length;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [BYTE_W-1:0]      i_cfg_data;

    t_cfg              cfg_shadow;
    logic [CRC_W-1:0]  frame_crc;
    logic [LEN_W-1:0]  frame_len;
    logic [BYTE_W-1:0] hdr_address;
    logic [BYTE_W-1:0] hdr_function;
    logic [BYTE_W-1:0] hdr_count;

    frame_result_t frame_results_q[$];

    int send_idle_pct;
    int recv_stall_pct;
    int words_sent;
    int mismatches;
    int quiet_cycles;

    modbus_rtu_frame_checker DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_byte_value      (i_byte_value),
        .i_frame_end       (i_frame_end),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_frame_valid     (o_frame_valid),
        .o_heartbeat_match (o_heartbeat_match),
        .o_frame_length    (o_frame_length),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    function automatic logic [CRC_W-1:0] crc16_step(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [BYTE_W-1:0] pick_address();
        case ($urandom_range(0, 5))
            0: return cfg_shadow.max_address;
            1: return cfg_shadow.max_address + 8'd1;
            2: return 8'h00;
            3: return 8'hFF;
            4: return cfg_shadow.heartbeat_address;
            default: return rand_byte();
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] pick_function();
        case ($urandom_range(0, 6))
            0: return 8'h00;
            1: return 8'h01;
            2: return MAX_FUNCTION;
            3: return MAX_FUNCTION + 8'd1;
            4: return 8'hFF;
            5: return cfg_shadow.heartbeat_function;
            default: return rand_byte();
        endcase
    endfunction

    task automatic clear_frame_state();
        frame_crc    = CRC_INIT;
        frame_len    = '0;
        hdr_address  = '0;
        hdr_function = '0;
        hdr_count    = '0;
    endtask

    task automatic predict_frame_byte(input logic [BYTE_W-1:0] b, input logic last);
        frame_result_t r;
        logic          crc_ok;
        case (frame_len)
            9'd0: hdr_address  = b;
            9'd1: hdr_function = b;
            9'd2: hdr_count    = b;
            default: ;
        endcase
        frame_crc = crc16_step(frame_crc, b);
        if (frame_len < MAX_FRAME) begin
            frame_len = frame_len + 9'd1;
        end
        if (last) begin
            crc_ok = (frame_crc == '0);
            r.frame_valid = (frame_len >= MIN_VALID_LEN) && crc_ok &&
                            (hdr_address <= cfg_shadow.max_address) &&
                            (hdr_function >= 8'd1) && (hdr_function <= MAX_FUNCTION);
            r.heartbeat_match = (frame_len == HEARTBEAT_LEN) && crc_ok &&
                                (hdr_address == cfg_shadow.heartbeat_address) &&
                                (hdr_function == cfg_shadow.heartbeat_function) &&
                                (hdr_count == cfg_shadow.heartbeat_count);
            r.frame_length = frame_len;
            frame_results_q.push_back(r);
            clear_frame_state();
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_byte_value <= b;
        i_frame_end  <= last;
        do @(posedge i_clk); while (o_in_stall);
        predict_frame_byte(b, last);
        words_sent++;
    endtask

    task automatic send_frame(input byte_q_t body, input bit add_crc, input bit corrupt);
        byte_q_t          data;
        logic [CRC_W-1:0] crc;
        int               idx;
        data = body;
        if (add_crc) begin
            crc = CRC_INIT;
            foreach (body[i]) crc = crc16_step(crc, body[i]);
            data.push_back(crc[7:0]);
            data.push_back(crc[15:8]);
        end
        if (corrupt) begin
            idx = $urandom_range(0, data.size() - 1);
            data[idx] = data[idx] ^ (8'h01 << $urandom_range(0, 7));
        end
        foreach (data[i]) send_byte(data[i], i == data.size() - 1);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (frame_results_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [BYTE_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            CFG_MAX_ADDRESS:        cfg_shadow.max_address        = data;
            CFG_HEARTBEAT_ADDRESS:  cfg_shadow.heartbeat_address  = data;
            CFG_HEARTBEAT_FUNCTION: cfg_shadow.heartbeat_function = data;
            CFG_HEARTBEAT_COUNT:    cfg_shadow.heartbeat_count    = data;
            default: ;
        endcase
    endtask

    task automatic apply_config(input t_cfg c);
        wait_drained();
        write_reg(CFG_MAX_ADDRESS, c.max_address);
        write_reg(CFG_HEARTBEAT_ADDRESS, c.heartbeat_address);
        write_reg(CFG_HEARTBEAT_FUNCTION, c.heartbeat_function);
        write_reg(CFG_HEARTBEAT_COUNT, c.heartbeat_count);
        write_reg(CFG_INDEX_W'($urandom_range(CFG_HEARTBEAT_COUNT + 1, 255)), rand_byte());
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_frames();
        byte_q_t body;
        body = {RST_HEARTBEAT_ADDRESS, RST_HEARTBEAT_FUNCTION, RST_HEARTBEAT_COUNT,
                8'h12, 8'h34};
        send_frame(body, 1'b1, 1'b0);
        body = {8'hFF};
        send_frame(body, 1'b0, 1'b0);
        body = {RST_MAX_ADDRESS, MAX_FUNCTION};
        send_frame(body, 1'b1, 1'b0);
        body = {RST_MAX_ADDRESS + 8'd1, 8'h01};
        send_frame(body, 1'b1, 1'b0);
        body = {RST_HEARTBEAT_ADDRESS, RST_HEARTBEAT_FUNCTION, RST_HEARTBEAT_COUNT,
                8'h00, 8'h00};
        send_frame(body, 1'b1, 1'b1);
    endtask

    task automatic test_overlong_frames(input int total_len);
        byte_q_t body;
        body.push_back(pick_address());
        body.push_back(pick_function());
        while (body.size() < total_len - 2) body.push_back(rand_byte());
        send_frame(body, 1'b1, 1'b0);
    endtask

    task automatic test_random_frames(input int num_words);
        byte_q_t body;
        int      start;
        int      kind;
        int      n;
        start = words_sent;
        while (words_sent - start < num_words) begin
            body.delete();
            kind = $urandom_range(0, 99);
            if (kind < 25) begin
                body.push_back(cfg_shadow.heartbeat_address);
                body.push_back(cfg_shadow.heartbeat_function);
                body.push_back(cfg_shadow.heartbeat_count);
                body.push_back(rand_byte());
                body.push_back(rand_byte());
                if ($urandom_range(0, 4) == 0) begin
                    body[$urandom_range(0, 2)] = rand_byte();
                end
                send_frame(body, 1'b1, $urandom_range(0, 9) == 0);
            end else if (kind < 85) begin
                body.push_back(pick_address());
                if ($urandom_range(0, 9) != 0) begin
                    body.push_back(pick_function());
                    n = $urandom_range(0, 6);
                    if (n > 0) begin
                        body.push_back($urandom_range(0, 1) ? cfg_shadow.heartbeat_count
                                                            : rand_byte());
                        repeat (n - 1) body.push_back(rand_byte());
                    end
                end
                send_frame(body, 1'b1, $urandom_range(0, 6) == 0);
            end else begin
                n = $urandom_range(1, 10);
                repeat (n) body.push_back(rand_byte());
                send_frame(body, 1'b0, 1'b0);
            end
        end
    endtask

    function automatic t_cfg random_cfg();
        t_cfg c;
        c.max_address        = rand_byte();
        c.heartbeat_address  = rand_byte();
        c.heartbeat_function = rand_byte();
        c.heartbeat_count    = rand_byte();
        return c;
    endfunction

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        frame_result_t exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (frame_results_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result valid=%0b heartbeat=%0b len=%0d",
                                          o_frame_valid, o_heartbeat_match, o_frame_length));
            end else begin
                exp_r = frame_results_q.pop_front();
                if (o_frame_valid !== exp_r.frame_valid) begin
                    report_mismatch($sformatf("frame_valid got %0b want %0b",
                                              o_frame_valid, exp_r.frame_valid));
                end
                if (o_heartbeat_match !== exp_r.heartbeat_match) begin
                    report_mismatch($sformatf("heartbeat_match got %0b want %0b",
                                              o_heartbeat_match, exp_r.heartbeat_match));
                end
                if (o_frame_length !== exp_r.frame_length) begin
                    report_mismatch($sformatf("frame_length got %0d want %0d",
                                              o_frame_length, exp_r.frame_length));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                     (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        t_cfg c;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_byte_value   = '0;
        i_frame_end    = 1'b0;
        i_out_stall    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        send_idle_pct  = 30;
        recv_stall_pct = 80;
        words_sent     = 0;
        mismatches     = 0;
        quiet_cycles   = 0;
        cfg_shadow     = '{RST_MAX_ADDRESS, RST_HEARTBEAT_ADDRESS,
                           RST_HEARTBEAT_FUNCTION, RST_HEARTBEAT_COUNT};
        clear_frame_state();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_frames();

        apply_config('{8'h00, 8'h00, 8'h00, 8'h00});
        test_overlong_frames(MAX_FRAME - 1);
        test_random_frames(25);
        apply_config(random_cfg());
        test_random_frames(25);

        send_idle_pct  = 80;
        recv_stall_pct = 30;
        apply_config('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
        test_overlong_frames(MAX_FRAME);
        test_random_frames(25);
        apply_config(random_cfg());
        test_random_frames(25);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        apply_config('{RST_MAX_ADDRESS, RST_HEARTBEAT_ADDRESS,
                       RST_HEARTBEAT_FUNCTION, RST_HEARTBEAT_COUNT});
        test_overlong_frames(MAX_FRAME + 1 + $urandom_range(0, 13));
        test_random_frames(25);
        c = random_cfg();
        c.max_address = 8'd127;
        apply_config(c);
        test_random_frames(25);

        wait_drained();
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
